/* rtl/core/lfmc_pkg.sv */
// Package for the LFM chirp frame generator: sizes, register indexes, shared types, sine table.
package lfmc_pkg;

    localparam int PHASE_W    = 32;
    localparam int ADDR_BITS  = 12;
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 18;
    localparam int PULSE_W    = 16;
    localparam int EDGE_W     = 15;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Quarter-wave table geometry and amplitude.
    localparam int QBITS = ADDR_BITS - 2;
    localparam int QSIZE = 1 << QBITS;
    localparam int AMP_W = SAMPLE_W - 1;
    localparam logic [63:0] AMP = 64'((64'd1 << AMP_W) - 64'd1);

    // Q60 constants used while building the table.
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
    localparam logic [63:0] HALF_Q60    = 64'd1 << 59;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LIN_WORD      = 3'd0,
        REG_QUAD_WORD     = 3'd1,
        REG_PHASE_OFFSET  = 3'd2,
        REG_PULSE_SAMPLES = 3'd3,
        REG_PRI_SAMPLES   = 3'd4,
        REG_EDGE_PAD      = 3'd5
    } cfg_reg_t;

    // One sample as decided by the frame controller.
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic                 in_pulse;
        logic                 frame_last;
    } sample_ctl_t;

    typedef logic [AMP_W-1:0] sin_tab_t [0:QSIZE];

    // (a*b + add) >> 60, truncated to 64 bits.
    function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] add);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b} + {64'd0, add};
        return p[123:60];
    endfunction

    // Unsigned quotient n / d, one bit per step by restoring shift and subtract.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry r holds round(AMP * sin(pi/2 * r / QSIZE)), from a Q60 Taylor series.
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t    tab;
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int r = 0; r <= QSIZE; r++)
        begin
            frac = 64'(r) << (62 - ADDR_BITS);
            x    = mul60(HALF_PI_Q60, frac, HALF_Q60);
            x2   = mul60(x, x, HALF_Q60);
            term = x;
            sum  = x;
            for (int k = 1; k < 40; k++)
            begin
                if (term != 64'd0)
                begin
                    term = udiv64(mul60(term, x2, HALF_Q60),
                                  64'(2 * k) * 64'(2 * k + 1));
                    if (k[0])
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
            end
            v = mul60(AMP, sum, HALF_Q60);
            if (v > AMP)
                v = AMP;
            tab[r] = v[AMP_W-1:0];
        end
        return tab;
    endfunction

endpackage

/* rtl/core/lfmc_frame_ctrl.sv */
// Frame sequencer: configuration registers, frame position and chirp phase accumulators.
module lfmc_frame_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lfmc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lfmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             step,
    input  logic                             restart,
    output lfmc_pkg::sample_ctl_t            sample
);
    import lfmc_pkg::*;

    logic [PHASE_W-1:0] lin_word_reg;
    logic [PHASE_W-1:0] quad_word_reg;
    logic [PHASE_W-1:0] phase_offset_reg;
    logic [PULSE_W-1:0] pulse_samples_reg;
    logic [PULSE_W-1:0] pri_samples_reg;
    logic [EDGE_W-1:0]  edge_pad_reg;

    logic [POS_W-1:0]   position_reg;
    logic [POS_W-1:0]   position_next;
    logic [PHASE_W-1:0] phase_acc_reg;
    logic [PHASE_W-1:0] phase_acc_next;
    logic [PHASE_W-1:0] phase_step_reg;
    logic [PHASE_W-1:0] phase_step_next;

    logic [POS_W-1:0]   pos;
    logic [PULSE_W-1:0] pri_pad;
    logic [POS_W-1:0]   frame_len;
    logic [POS_W-1:0]   last_pos;
    logic [POS_W-1:0]   chirp_idx;
    logic               in_pulse;
    logic               frame_last;
    logic [PHASE_W-1:0] cur_phase;
    logic [PHASE_W-1:0] cur_step;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_word_reg      <= '0;
            quad_word_reg     <= '0;
            phase_offset_reg  <= '0;
            pulse_samples_reg <= PULSE_W'(1);
            pri_samples_reg   <= '0;
            edge_pad_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LIN_WORD:      lin_word_reg      <= cfg_data[PHASE_W-1:0];
                REG_QUAD_WORD:     quad_word_reg     <= cfg_data[PHASE_W-1:0];
                REG_PHASE_OFFSET:  phase_offset_reg  <= cfg_data[PHASE_W-1:0];
                REG_PULSE_SAMPLES: pulse_samples_reg <= cfg_data[PULSE_W-1:0];
                REG_PRI_SAMPLES:   pri_samples_reg   <= cfg_data[PULSE_W-1:0];
                REG_EDGE_PAD:      edge_pad_reg      <= cfg_data[EDGE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Frame geometry and the place of this sample in it.
    always_comb
    begin
        pos = restart ? '0 : position_reg;

        if (pri_samples_reg > pulse_samples_reg)
            pri_pad = pri_samples_reg - pulse_samples_reg;
        else
            pri_pad = '0;

        frame_len = POS_W'({edge_pad_reg, 1'b0}) + POS_W'(pulse_samples_reg)
                  + POS_W'(pri_pad);
        // An empty frame counts as one sample long.
        last_pos   = (frame_len == '0) ? '0 : frame_len - POS_W'(1);
        frame_last = (pos >= last_pos);

        chirp_idx = pos - POS_W'(edge_pad_reg);
        in_pulse  = (pos >= POS_W'(edge_pad_reg))
                 && (chirp_idx < POS_W'(pulse_samples_reg));
    end

    // Chirp phase: the first pulse sample restarts from the offset and base increment.
    always_comb
    begin
        if (chirp_idx == '0)
        begin
            cur_phase = phase_offset_reg;
            cur_step  = lin_word_reg + quad_word_reg;
        end
        else
        begin
            cur_phase = phase_acc_reg;
            cur_step  = phase_step_reg;
        end

        if (in_pulse)
        begin
            phase_acc_next  = cur_phase + cur_step;
            phase_step_next = cur_step + {quad_word_reg[PHASE_W-2:0], 1'b0};
        end
        else
        begin
            phase_acc_next  = phase_acc_reg;
            phase_step_next = phase_step_reg;
        end

        position_next = frame_last ? '0 : pos + POS_W'(1);
    end

    // State advances once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
        end
        else if (step)
        begin
            position_reg   <= position_next;
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
        end
    end

    assign sample.addr       = cur_phase[PHASE_W-1 -: ADDR_BITS];
    assign sample.in_pulse   = in_pulse;
    assign sample.frame_last = frame_last;

endmodule

/* rtl/core/lfm_chirp_frame_generator_top.sv */
// Top level of the LFM chirp frame generator: stream ports, table lookup pipeline, output stage.
//
//  channel | direction | signals                                  | content
//  --------+-----------+------------------------------------------+-----------------------------
//  s_axis  | in        | s_tvalid s_tready s_tdata[7:0]           | restart tick
//  m_axis  | out       | m_tvalid m_tready m_tdata m_tlast m_tuser| I/Q sample, frame end, pulse
//  cfg     | in        | cfg_we cfg_addr cfg_data                 | register writes
//
// One sample per clock is accepted and produced while m_tready stays high; a sample passes
// through three registers (frame step, sine table read, quadrant fold) before it is valid
// on m_axis. Each stage holds its data while the next one is full and cannot move on, so
// input is still accepted while a result waits on m_tready until all three stages are full.
// Reset clears the frame position, the phase accumulators and the pipeline valid bits; the
// configuration registers reset to zero, except the pulse sample count, which resets to one.
module lfm_chirp_frame_generator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [0] restart, [7:1] zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [15:0] i_sample, [31:16] q_sample
    output logic                             m_tlast,   // frame_last
    output logic                             m_tuser,   // in_pulse
    input  logic                             cfg_we,
    input  logic [lfmc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lfmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lfmc_pkg::*;

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    sample_ctl_t          sample;
    logic                 accept;
    logic                 en1;
    logic                 en2;
    logic                 en_out;

    logic                 v1_reg;
    sample_ctl_t          s1_reg;

    logic                 v2_reg;
    logic [AMP_W-1:0]     sin_a_reg;
    logic [AMP_W-1:0]     sin_b_reg;
    logic [1:0]           quadrant_reg;
    logic                 pulse2_reg;
    logic                 last2_reg;

    logic                 vo_reg;
    logic [SAMPLE_W-1:0]  i_reg;
    logic [SAMPLE_W-1:0]  q_reg;
    logic                 pulse_o_reg;
    logic                 last_o_reg;

    logic [QBITS-1:0]     rom_r;
    logic [QBITS:0]       rom_r_mirror;
    logic [SAMPLE_W-1:0]  pos_a;
    logic [SAMPLE_W-1:0]  pos_b;
    logic [SAMPLE_W-1:0]  i_next;
    logic [SAMPLE_W-1:0]  q_next;

    // Stage enables: a stage loads when it is empty or its contents move on.
    assign en_out   = !vo_reg || m_tready;
    assign en2      = !v2_reg || en_out;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && s_tready;

    lfmc_frame_ctrl u_frame_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .step     (accept),
        .restart  (s_tdata[0]),
        .sample   (sample)
    );

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= accept;
            if (en2)
                v2_reg <= v1_reg;
            if (en_out)
                vo_reg <= v2_reg;
        end
    end

    // Stage 1: table address and sample flags.
    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= sample;
    end

    // Stage 2: quarter-wave table, read at r and at its mirror QSIZE - r.
    assign rom_r        = s1_reg.addr[QBITS-1:0];
    assign rom_r_mirror = (QBITS + 1)'(QSIZE) - {1'b0, rom_r};

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            sin_a_reg    <= SIN_TAB[{1'b0, rom_r}];
            sin_b_reg    <= SIN_TAB[rom_r_mirror];
            quadrant_reg <= s1_reg.addr[ADDR_BITS-1 -: 2];
            pulse2_reg   <= s1_reg.in_pulse;
            last2_reg    <= s1_reg.frame_last;
        end
    end

    // Quadrant fold to cosine and sine; padding samples are zero.
    always_comb
    begin
        pos_a = {1'b0, sin_a_reg};
        pos_b = {1'b0, sin_b_reg};
        unique case (quadrant_reg)
            2'd0:
            begin
                i_next = pos_b;
                q_next = pos_a;
            end
            2'd1:
            begin
                i_next = -pos_a;
                q_next = pos_b;
            end
            2'd2:
            begin
                i_next = -pos_b;
                q_next = -pos_a;
            end
            default:
            begin
                i_next = pos_a;
                q_next = -pos_b;
            end
        endcase
        if (!pulse2_reg)
        begin
            i_next = '0;
            q_next = '0;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            i_reg       <= i_next;
            q_reg       <= q_next;
            pulse_o_reg <= pulse2_reg;
            last_o_reg  <= last2_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {q_reg, i_reg};
    assign m_tlast  = last_o_reg;
    assign m_tuser  = pulse_o_reg;

endmodule
